FILE: rtl/core/gic_pkg.sv
package gic_pkg;

    localparam logic [2:0] OP_LINE    = 3'd0;
    localparam logic [2:0] OP_ENABLE  = 3'd1;
    localparam logic [2:0] OP_DISABLE = 3'd2;
    localparam logic [2:0] OP_RESOLVE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] POL_EMPTY  = 2'd0;
    localparam logic [1:0] POL_ASIS   = 2'd1;
    localparam logic [1:0] POL_INVERT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MERGE,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
        logic resolve;
    } t_scan_ctl;

    // index of the highest set bit, binary search
    function automatic logic [4:0] f_top_bit(input logic [31:0] v);
        logic [4:0]  b;
        logic [31:0] x;
        b = 5'd0;
        x = v;
        if (x[31:16] != 16'd0) begin
            b[4] = 1'b1;
            x    = {16'd0, x[31:16]};
        end
        if (x[15:8] != 8'd0) begin
            b[3] = 1'b1;
            x    = {8'd0, x[31:8]};
        end
        if (x[7:4] != 4'd0) begin
            b[2] = 1'b1;
            x    = {4'd0, x[31:4]};
        end
        if (x[3:2] != 2'd0) begin
            b[1] = 1'b1;
            x    = {2'd0, x[31:2]};
        end
        if (x[1]) begin
            b[0] = 1'b1;
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/gic_ram.sv
module gic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 45
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/gic_scan.sv
module gic_scan #(
    parameter int LINE_WORDS  = 3,
    parameter int GROUP_COUNT = 15
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  gic_pkg::t_scan_ctl                               i_ctl,
    input  logic [(GROUP_COUNT > 1 ? $clog2(GROUP_COUNT) : 1)-1:0] i_group,
    input  logic [(LINE_WORDS > 1 ? $clog2(LINE_WORDS) : 1)-1:0]   i_word,
    input  logic [31:0]                                      i_status,
    output logic                                             o_found,
    output logic [3:0]                                       o_group,
    output logic [6:0]                                       o_irq,
    output logic [14:0]                                      o_gmask
);
    import gic_pkg::*;

    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    logic                   r_found, n_found;
    logic [GW-1:0]          r_group, n_group;
    logic [6:0]             r_irq, n_irq;
    logic [GROUP_COUNT-1:0] r_gmask, n_gmask;
    logic                   hit;

    assign hit = i_ctl.step && (i_status != 32'd0);

    always_comb begin
        n_found = r_found;
        n_group = r_group;
        n_irq   = r_irq;
        n_gmask = r_gmask;
        if (i_ctl.start) begin
            n_found = 1'b0;
            n_group = '0;
            n_irq   = 7'd0;
            n_gmask = '0;
        end else if (hit) begin
            n_gmask[i_group] = 1'b1;
            if (i_ctl.resolve && !r_found) begin
                n_found = 1'b1;
                n_group = i_group;
                n_irq   = 7'({i_word, f_top_bit(i_status)});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_group <= '0;
            r_irq   <= 7'd0;
            r_gmask <= '0;
        end else begin
            r_found <= n_found;
            r_group <= n_group;
            r_irq   <= n_irq;
            r_gmask <= n_gmask;
        end
    end

    assign o_found = r_found;
    assign o_group = 4'(r_group);
    assign o_irq   = r_irq;
    assign o_gmask = 15'(r_gmask);
endmodule

FILE: rtl/core/grouped_interrupt_controller.sv
// An accepted enable passes through the S_MERGE state (read-modify-write of the group
// membership RAM) between S_UPDATE and S_SCAN.
// Throughput: one item at a time; the status scan reads one membership word per
// cycle from a single RAM port, so the scan length sets the rate. Synchronous active-low
// reset clears all enables, polarities, wake bits, raw lines and group membership.
module grouped_interrupt_controller #(
    parameter int LINE_WORDS  = 3,
    parameter int GROUP_COUNT = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // irq_index, polarity_code, group_select, line_word_index, line_value
    input  logic [47:0] s_axis_tdata,
    // opcode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status_code, found, served_group, served_irq, group_pending_mask, wake_request
    output logic [31:0] m_axis_tdata
);
    import gic_pkg::*;

    localparam int WW    = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int GW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int DEPTH = GROUP_COUNT * LINE_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;

    logic [2:0]  r_op;
    logic [6:0]  r_irq;
    logic [1:0]  r_pol_code;
    logic [3:0]  r_grp;
    logic [1:0]  r_lw;
    logic [31:0] r_value;

    logic [31:0] r_en   [LINE_WORDS];
    logic [31:0] r_pol  [LINE_WORDS];
    logic [31:0] r_wake [LINE_WORDS];
    logic [31:0] r_raw  [LINE_WORDS];
    logic [31:0] n_en   [LINE_WORDS];
    logic [31:0] n_pol  [LINE_WORDS];
    logic [31:0] n_wake [LINE_WORDS];
    logic [31:0] n_raw  [LINE_WORDS];

    logic [DEPTH-1:0] r_valid, n_valid;

    logic [GW-1:0] r_g, n_g, r_gd;
    logic [WW-1:0] r_w, n_w, r_wd;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_step_d, r_rd_valid, r_status;

    logic          irq_ok, grp_ok, en_ok, scan_last, ram_we;
    logic [1:0]    iw;
    logic [31:0]   bit_mask, mem_word, stat_word;
    logic [AW-1:0] tgt, rd_addr;
    logic [31:0]   ram_q;
    logic          wake;
    t_scan_ctl     scan_ctl;
    logic          sc_found;
    logic [3:0]    sc_group;
    logic [6:0]    sc_irq;
    logic [14:0]   sc_gmask;

    assign iw       = r_irq[6:5];
    assign bit_mask = 32'd1 << r_irq[4:0];
    assign irq_ok   = 32'(r_irq) < LINE_WORDS * 32;
    assign grp_ok   = 32'(r_grp) < GROUP_COUNT;
    assign en_ok    = (r_op == OP_ENABLE) && (r_pol_code != POL_EMPTY) && irq_ok && grp_ok;
    assign tgt      = AW'(32'(r_grp) * LINE_WORDS + 32'(iw));
    assign scan_last = (r_g == GW'(GROUP_COUNT - 1)) && (r_w == WW'(LINE_WORDS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_axis_tvalid) n_state = S_UPDATE;
            S_UPDATE: n_state = en_ok ? S_MERGE : S_SCAN;
            S_MERGE:  n_state = S_SCAN;
            S_SCAN:   if (scan_last) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_OUT;
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = 1'b0;
        m_axis_tvalid    = 1'b0;
        ram_we           = 1'b0;
        rd_addr          = tgt;
        scan_ctl.start   = 1'b0;
        scan_ctl.step    = r_step_d;
        scan_ctl.resolve = (r_op == OP_RESOLVE);
        case (r_state)
            S_IDLE:   s_axis_tready = 1'b1;
            S_UPDATE: scan_ctl.start = 1'b1;
            S_MERGE:  ram_we = 1'b1;
            S_SCAN:   rd_addr = r_addr;
            S_OUT:    m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign mem_word  = r_rd_valid ? ram_q : 32'd0;
    assign stat_word = (r_raw[r_wd] ^ r_pol[r_wd]) & r_en[r_wd] & mem_word;

    always_comb begin
        n_en    = r_en;
        n_pol   = r_pol;
        n_wake  = r_wake;
        n_raw   = r_raw;
        n_valid = r_valid;
        if (r_state == S_UPDATE) begin
            case (r_op)
                OP_LINE: begin
                    for (int w = 0; w < LINE_WORDS; w++) begin
                        if (32'(r_lw) == w) n_raw[w] = r_value;
                    end
                end
                OP_ENABLE: begin
                    for (int w = 0; w < LINE_WORDS; w++) begin
                        if (en_ok && 32'(iw) == w) begin
                            n_en[w]   = r_en[w] | bit_mask;
                            n_wake[w] = r_wake[w] | bit_mask;
                            if (r_pol_code == POL_ASIS) begin
                                n_pol[w] = r_pol[w] & ~bit_mask;
                            end else if (r_pol_code == POL_INVERT) begin
                                n_pol[w] = r_pol[w] | bit_mask;
                            end
                        end
                    end
                end
                OP_DISABLE: begin
                    for (int w = 0; w < LINE_WORDS; w++) begin
                        if (irq_ok && 32'(iw) == w) n_en[w] = r_en[w] & ~bit_mask;
                    end
                end
                OP_CLEAR: begin
                    for (int w = 0; w < LINE_WORDS; w++) begin
                        n_en[w]   = 32'd0;
                        n_pol[w]  = 32'd0;
                        n_wake[w] = 32'd0;
                    end
                    n_valid = '0;
                end
                default: ;
            endcase
        end else if (r_state == S_MERGE) begin
            n_valid[tgt] = 1'b1;
        end
    end

    always_comb begin
        n_g    = r_g;
        n_w    = r_w;
        n_addr = r_addr;
        if (r_state == S_UPDATE) begin
            n_g    = '0;
            n_w    = '0;
            n_addr = '0;
        end else if (r_state == S_SCAN) begin
            n_addr = r_addr + AW'(1);
            if (r_w == WW'(LINE_WORDS - 1)) begin
                n_w = '0;
                n_g = r_g + GW'(1);
            end else begin
                n_w = r_w + WW'(1);
            end
        end
    end

    always_comb begin
        wake = 1'b0;
        for (int w = 0; w < LINE_WORDS; w++) begin
            if (((r_raw[w] ^ r_pol[w]) & r_wake[w]) != 32'd0) wake = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_status <= 1'b0;
            r_step_d <= 1'b0;
            for (int w = 0; w < LINE_WORDS; w++) begin
                r_en[w]   <= 32'd0;
                r_pol[w]  <= 32'd0;
                r_wake[w] <= 32'd0;
                r_raw[w]  <= 32'd0;
            end
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_step_d <= (r_state == S_SCAN);
            r_en     <= n_en;
            r_pol    <= n_pol;
            r_wake   <= n_wake;
            r_raw    <= n_raw;
            if (r_state == S_UPDATE) begin
                r_status <= (r_op == OP_ENABLE) && (r_pol_code == POL_EMPTY);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op       <= s_axis_tuser;
            r_irq      <= s_axis_tdata[6:0];
            r_pol_code <= s_axis_tdata[8:7];
            r_grp      <= s_axis_tdata[12:9];
            r_lw       <= s_axis_tdata[14:13];
            r_value    <= s_axis_tdata[46:15];
        end
        r_g        <= n_g;
        r_w        <= n_w;
        r_addr     <= n_addr;
        r_gd       <= r_g;
        r_wd       <= r_w;
        r_rd_valid <= r_valid[rd_addr];
    end

    gic_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_member_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tgt),
        .i_wdata (mem_word | bit_mask),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    gic_scan #(
        .LINE_WORDS  (LINE_WORDS),
        .GROUP_COUNT (GROUP_COUNT)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_group  (r_gd),
        .i_word   (r_wd),
        .i_status (stat_word),
        .o_found  (sc_found),
        .o_group  (sc_group),
        .o_irq    (sc_irq),
        .o_gmask  (sc_gmask)
    );

    assign m_axis_tdata = {3'd0, wake, sc_gmask, sc_irq, sc_group, sc_found, r_status};
endmodule

FILE: rtl/core/gic_checker.sv
module gic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // one item in flight: no new transfer while a result is offered
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
        else $error("block not busy after input transfer");

    a_empty_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[12:2] == 11'd0))
        else $error("served fields set without found");

    a_status_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("error status on a resolve");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
endmodule

bind grouped_interrupt_controller gic_checker u_gic_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/gic_report_checker.sv
module gic_report_checker #(
    parameter int LINE_WORDS  = 3,
    parameter int GROUP_COUNT = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // irq_index, polarity_code, group_select, line_word_index, line_value
    input  logic [47:0] i_s_tdata,
    // opcode
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // status_code, found, served_group, served_irq, group_pending_mask, wake_request
    input  logic [31:0] i_m_tdata,
    output int unsigned o_errors,
    output int unsigned o_waiting,
    output int unsigned o_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import gic_pkg::*;

    typedef struct packed {
        logic        status_code;
        logic        found;
        logic [3:0]  served_group;
        logic [6:0]  served_irq;
        logic [14:0] group_pending_mask;
        logic        wake_request;
    } t_report;

    logic [31:0] enable_mask   [LINE_WORDS];
    logic [31:0] polarity_mask [LINE_WORDS];
    logic [31:0] wake_mask     [LINE_WORDS];
    logic [31:0] raw_level     [LINE_WORDS];
    logic [31:0] member_mask   [GROUP_COUNT][LINE_WORDS];

    t_report     expected_reports[$];
    int unsigned error_count;
    int unsigned hit_count;

    function automatic void clear_settings();
        for (int w = 0; w < LINE_WORDS; w++) begin
            enable_mask[w]   = '0;
            polarity_mask[w] = '0;
            wake_mask[w]     = '0;
            for (int g = 0; g < GROUP_COUNT; g++) begin
                member_mask[g][w] = '0;
            end
        end
    endfunction

    function automatic t_report controller_step(input logic [2:0] op, input logic [6:0] irq,
                                                input logic [1:0] pol, input logic [3:0] grp,
                                                input logic [1:0] lw, input logic [31:0] lv);
        t_report     rep;
        logic [1:0]  word;
        logic [31:0] bitm;
        logic [31:0] hits;
        logic        irq_ok;
        int          top;
        rep    = '0;
        word   = irq[6:5];
        bitm   = 32'd1 << irq[4:0];
        irq_ok = irq < LINE_WORDS * 32;
        case (op)
            OP_LINE: begin
                if (lw < LINE_WORDS) raw_level[lw] = lv;
            end
            OP_ENABLE: begin
                if (pol == POL_EMPTY) begin
                    rep.status_code = 1'b1;
                end else if (irq_ok && grp < GROUP_COUNT) begin
                    enable_mask[word] &= ~bitm;
                    if (pol == POL_ASIS) polarity_mask[word] &= ~bitm;
                    else if (pol == POL_INVERT) polarity_mask[word] |= bitm;
                    member_mask[grp][word] |= bitm;
                    wake_mask[word]        |= bitm;
                    enable_mask[word]      |= bitm;
                end
            end
            OP_DISABLE: begin
                if (irq_ok) enable_mask[word] &= ~bitm;
            end
            OP_CLEAR: begin
                clear_settings();
            end
            default: begin
            end
        endcase
        for (int g = 0; g < GROUP_COUNT; g++) begin
            for (int w = 0; w < LINE_WORDS; w++) begin
                hits = (raw_level[w] ^ polarity_mask[w]) & enable_mask[w] & member_mask[g][w];
                if (hits != 0) begin
                    rep.group_pending_mask[g] = 1'b1;
                    if (op == OP_RESOLVE && !rep.found) begin
                        top = 0;
                        for (int b = 0; b < 32; b++) begin
                            if (hits[b]) top = b;
                        end
                        rep.found        = 1'b1;
                        rep.served_group = 4'(g);
                        rep.served_irq   = 7'(w * 32 + top);
                    end
                end
            end
        end
        for (int w = 0; w < LINE_WORDS; w++) begin
            if (((raw_level[w] ^ polarity_mask[w]) & wake_mask[w]) != 0) rep.wake_request = 1'b1;
        end
        return rep;
    endfunction

    task automatic compare_field(input string name, input int unsigned expv,
                                 input int unsigned actv);
        if (expv != actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report exp_rep;
        t_report act_rep;
        if (!i_rst_n) begin
            clear_settings();
            for (int w = 0; w < LINE_WORDS; w++) raw_level[w] = '0;
            expected_reports.delete();
            error_count = 0;
            hit_count   = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_reports.push_back(controller_step(i_s_tuser, i_s_tdata[6:0],
                    i_s_tdata[8:7], i_s_tdata[12:9], i_s_tdata[14:13], i_s_tdata[46:15]));
            end
            if (i_m_tvalid && i_m_tready) begin
                act_rep = {i_m_tdata[0], i_m_tdata[1], i_m_tdata[5:2], i_m_tdata[12:6],
                           i_m_tdata[27:13], i_m_tdata[28]};
                if (expected_reports.size() == 0) begin
                    $error("result transfer with nothing expected: %h", i_m_tdata);
                    error_count++;
                end else begin
                    exp_rep = expected_reports.pop_front();
                    if (exp_rep.found) hit_count++;
                    compare_field("status_code", exp_rep.status_code, act_rep.status_code);
                    compare_field("found", exp_rep.found, act_rep.found);
                    compare_field("served_group", exp_rep.served_group, act_rep.served_group);
                    compare_field("served_irq", exp_rep.served_irq, act_rep.served_irq);
                    compare_field("group_pending_mask", exp_rep.group_pending_mask,
                                  act_rep.group_pending_mask);
                    compare_field("wake_request", exp_rep.wake_request, act_rep.wake_request);
                end
            end
        end
        o_errors  <= error_count;
        o_waiting <= expected_reports.size();
        o_hits    <= hit_count;
    end

endmodule

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gic_pkg::*;

    localparam int LINE_WORDS  = 3;
    localparam int GROUP_COUNT = 15;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int RANDOM_PER_PHASE = 170;
    localparam logic [1:0] POL_KEEP = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    int unsigned errors;
    int unsigned waiting;
    int unsigned hits;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned op_count[8];

    grouped_interrupt_controller #(
        .LINE_WORDS (LINE_WORDS),
        .GROUP_COUNT(GROUP_COUNT)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    gic_report_checker #(
        .LINE_WORDS (LINE_WORDS),
        .GROUP_COUNT(GROUP_COUNT)
    ) checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tready(s_axis_tready),
        .i_s_tdata (s_axis_tdata),
        .i_s_tuser (s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .i_m_tdata (m_axis_tdata),
        .o_errors  (errors),
        .o_waiting (waiting),
        .o_hits    (hits)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        cycle_count   <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** grouped_interrupt_controller: FAILED **");
            $finish;
        end
    end

    task automatic send(input logic [2:0] op, input logic [6:0] irq, input logic [1:0] pol,
                        input logic [3:0] grp, input logic [1:0] lw, input logic [31:0] lv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, lv, lw, grp, pol, irq};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        op_count[op]++;
    endtask

    task automatic send_random();
        int unsigned pick;
        logic [2:0]  op;
        logic [6:0]  irq;
        logic [1:0]  pol;
        logic [3:0]  grp;
        logic [1:0]  lw;
        logic [31:0] lv;
        pick = $urandom_range(0, 99);
        irq  = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(LINE_WORDS * 32, 127))
                                            : 7'($urandom_range(0, LINE_WORDS * 32 - 1));
        grp  = ($urandom_range(0, 19) == 0) ? 4'(GROUP_COUNT)
                                            : 4'($urandom_range(0, GROUP_COUNT - 1));
        lw   = ($urandom_range(0, 19) == 0) ? 2'(LINE_WORDS) : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pol = POL_ASIS;
            4, 5, 6, 7: pol = POL_INVERT;
            8:          pol = POL_EMPTY;
            default:    pol = POL_KEEP;
        endcase
        case ($urandom_range(0, 5))
            0:       lv = '0;
            1:       lv = '1;
            2:       lv = 32'd1 << $urandom_range(0, 31);
            3:       lv = $urandom() & $urandom() & $urandom();
            default: lv = $urandom();
        endcase
        if (pick < 25)      op = OP_LINE;
        else if (pick < 50) op = OP_ENABLE;
        else if (pick < 62) op = OP_DISABLE;
        else if (pick < 92) op = OP_RESOLVE;
        else if (pick < 96) op = OP_CLEAR;
        else                op = 3'(OP_CLEAR + $urandom_range(1, 3));
        send(op, irq, pol, grp, lw, lv);
    endtask

    initial begin
        int unsigned idle_plan[4];
        int unsigned stall_plan[4];
        idle_plan  = '{0, 76, 0, 11};
        stall_plan = '{0, 0, 76, 11};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LINE;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ranges, refusals, polarity keep, priority order
        send(OP_RESOLVE, 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(OP_LINE, 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'hFFFF_FFFF);
        send(OP_ENABLE, 7'd0, POL_ASIS, 4'(GROUP_COUNT - 1), 2'd0, 32'd0);
        send(OP_ENABLE, 7'd95, POL_INVERT, 4'd0, 2'd0, 32'd0);
        send(OP_ENABLE, 7'd10, POL_EMPTY, 4'd3, 2'd0, 32'd0);
        send(OP_ENABLE, 7'd127, POL_ASIS, 4'd3, 2'd0, 32'd0);
        send(OP_ENABLE, 7'd96, POL_INVERT, 4'd0, 2'd0, 32'd0);
        send(OP_ENABLE, 7'd5, POL_ASIS, 4'd15, 2'd0, 32'd0);
        send(OP_ENABLE, 7'd40, POL_KEEP, 4'd7, 2'd0, 32'd0);
        send(OP_LINE, 7'd0, POL_EMPTY, 4'd0, 2'd3, 32'hFFFF_FFFF);
        send(OP_LINE, 7'd0, POL_EMPTY, 4'd0, 2'd2, 32'd0);
        send(OP_LINE, 7'd0, POL_EMPTY, 4'd0, 2'd1, 32'h0000_0100);
        send(OP_RESOLVE, 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(OP_DISABLE, 7'd95, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(OP_RESOLVE, 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(OP_DISABLE, 7'd127, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(3'(OP_CLEAR + 1), 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(3'(OP_CLEAR + 2), 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(3'(OP_CLEAR + 3), 7'd127, POL_KEEP, 4'd15, 2'd3, 32'hFFFF_FFFF);
        send(OP_ENABLE, 7'd31, POL_ASIS, 4'(GROUP_COUNT - 1), 2'd0, 32'd0);
        send(OP_RESOLVE, 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(OP_DISABLE, 7'd40, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(OP_RESOLVE, 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(OP_CLEAR, 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);
        send(OP_RESOLVE, 7'd0, POL_EMPTY, 4'd0, 2'd0, 32'd0);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_plan[phase];
            stall_pct     = stall_plan[phase];
            repeat (RANDOM_PER_PHASE) send_random();
        end
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;

        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Covered %0d line updates, %0d enables, %0d disables, %0d clears, %0d others;",
                 op_count[OP_LINE], op_count[OP_ENABLE], op_count[OP_DISABLE],
                 op_count[OP_CLEAR], op_count[5] + op_count[6] + op_count[7]);
        $display("%0d resolves (%0d served an irq) across four sender/receiver idling mixes.",
                 op_count[OP_RESOLVE], hits);
        if (errors == 0) begin
            $display("** grouped_interrupt_controller: PASSED **");
        end else begin
            $display("** grouped_interrupt_controller: FAILED **");
        end
        $finish;
    end

endmodule
